// ===== design/wisu_pkg.sv =====
package wisu_pkg;

  // fixed widths of the transfer fields
  localparam int SLOT_IN_W = 6;
  localparam int STAMP_W   = 64;
  localparam int AVG_W     = 40;
  localparam int MAX_W     = 32;
  localparam int COUNT_W   = 7;

  // fraction bits of the average
  localparam int FRAC_W    = 8;

endpackage

// ===== design/windowed_interval_stats_unit.sv =====
// Windowed interval statistics, one sample ring per measurement slot.
// Input channel (in_valid/in_ready): slot plus start and end timestamps. The
// interval length, saturated to DELTA_BITS, is written into the slot's ring
// and the ring is then walked to give maximum, nonzero count and average.
// Result channel (out_valid/out_ready): average_q8 (8 fraction bits,
// truncated), maximum and valid_count; an out-of-range slot gives all zeros.
// From the input transfer to out_valid, the ring walk reads one entry a
// cycle from the single read port, then a restoring divider produces one
// quotient bit a cycle. An empty window skips the divider and an
// out-of-range slot goes straight to the result. One item is in flight at
// a time; in_ready stays low until the next item can start.
// After reset the rings and write pointers are swept to zero, one entry a
// cycle; in_ready is low then.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile, and its result waits until the register frees.
module windowed_interval_stats_unit #(
  parameter int SLOTS      = 64,
  parameter int WINDOW     = 64,
  parameter int DELTA_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wisu_pkg::SLOT_IN_W-1:0]    in_slot,
  input  logic [wisu_pkg::STAMP_W-1:0]      in_start_stamp,
  input  logic [wisu_pkg::STAMP_W-1:0]      in_end_stamp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wisu_pkg::AVG_W-1:0]        out_average_q8,
  output logic [wisu_pkg::MAX_W-1:0]        out_maximum,
  output logic [wisu_pkg::COUNT_W-1:0]      out_valid_count
);
  import wisu_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = DELTA_BITS + CW;
  localparam int DVW   = SUM_W + FRAC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PTR   = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_DIVGO = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [SW-1:0]         slot_r;
  logic                  slot_ok_r;
  logic [DELTA_BITS-1:0] sample_r;
  logic [IW:0]           scan_r;
  logic                  rd_vld_r;
  logic [SUM_W-1:0]      sum_r;
  logic [DELTA_BITS-1:0] max_r;
  logic [CW-1:0]         cnt_r;
  logic                  out_valid_r;
  logic [AVG_W-1:0]      avg_out_r;
  logic [MAX_W-1:0]      max_out_r;
  logic [COUNT_W-1:0]    cnt_out_r;

  logic                  clr_busy;
  logic [DELTA_BITS-1:0] ring_rdata;
  logic [IW-1:0]         ptr_rdata;
  logic [IW-1:0]         ptr_inc;
  logic                  div_busy;
  logic [AVG_W-1:0]      quotient;
  logic                  accept;
  logic                  out_free;

  // interval length with saturation
  logic                  stamp_gt;
  logic [STAMP_W-1:0]    stamp_diff;
  logic [DELTA_BITS-1:0] sample_in;

  assign stamp_gt   = in_end_stamp > in_start_stamp;
  assign stamp_diff = in_end_stamp - in_start_stamp;

  always_comb begin
    if (!stamp_gt) begin
      sample_in = '0;
    end else if (|stamp_diff[STAMP_W-1:DELTA_BITS]) begin
      sample_in = '1;
    end else begin
      sample_in = stamp_diff[DELTA_BITS-1:0];
    end
  end

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign ptr_inc  = (ptr_rdata == IW'(WINDOW - 1)) ? '0 : ptr_rdata + 1'b1;

  wisu_store #(
    .SLOTS      (SLOTS),
    .WINDOW     (WINDOW),
    .DELTA_BITS (DELTA_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_busy   (clr_busy),
    .slot       (slot_r),
    .rd_idx     (scan_r[IW-1:0]),
    .ring_rdata (ring_rdata),
    .ptr_rdata  (ptr_rdata),
    .ring_we    (state_r == S_WRITE),
    .wr_idx     (ptr_rdata),
    .wr_data    (sample_r),
    .ptr_we     (state_r == S_WRITE),
    .ptr_wdata  (ptr_inc)
  );

  wisu_div #(
    .DVW (DVW),
    .DSW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_DIVGO) && (cnt_r != '0)),
    .dividend ({sum_r, {FRAC_W{1'b0}}}),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (32'(in_slot) < SLOTS) ? S_PTR : S_DONE;
        end
      end
      S_PTR:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_r == (IW + 1)'(WINDOW - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = (cnt_r != '0) ? S_DIV : S_DONE;
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);
    end
  end

  // item capture and ring walk counter
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r    <= SW'(in_slot);
      slot_ok_r <= 32'(in_slot) < SLOTS;
      sample_r  <= sample_in;
    end
    if (state_r == S_WRITE) begin
      scan_r <= '0;
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  // shared accumulate and compare over the read data
  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= '0;
      max_r <= '0;
      cnt_r <= '0;
    end else if (rd_vld_r && (ring_rdata != '0)) begin
      sum_r <= sum_r + SUM_W'(ring_rdata);
      cnt_r <= cnt_r + 1'b1;
      if (ring_rdata > max_r) begin
        max_r <= ring_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      if (slot_ok_r && (cnt_r != '0)) begin
        avg_out_r <= quotient;
        max_out_r <= MAX_W'(max_r);
        cnt_out_r <= COUNT_W'(cnt_r);
      end else begin
        avg_out_r <= '0;
        max_out_r <= '0;
        cnt_out_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average_q8  = avg_out_r;
  assign out_maximum     = max_out_r;
  assign out_valid_count = cnt_out_r;

endmodule

// ===== design/wisu_store.sv =====
module wisu_store #(
  parameter int SLOTS      = 64,
  parameter int WINDOW     = 64,
  parameter int DELTA_BITS = 32,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int IW = $clog2(WINDOW)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  output logic                  clr_busy,
  input  logic [SW-1:0]         slot,
  input  logic [IW-1:0]         rd_idx,
  output logic [DELTA_BITS-1:0] ring_rdata,
  output logic [IW-1:0]         ptr_rdata,
  input  logic                  ring_we,
  input  logic [IW-1:0]         wr_idx,
  input  logic [DELTA_BITS-1:0] wr_data,
  input  logic                  ptr_we,
  input  logic [IW-1:0]         ptr_wdata
);

  logic [DELTA_BITS-1:0] ring_mem [SLOTS][WINDOW];
  logic [IW-1:0]         ptr_mem  [SLOTS];

  logic                  clr_busy_r;
  logic [SW-1:0]         clr_slot_r;
  logic [IW-1:0]         clr_idx_r;
  logic [DELTA_BITS-1:0] ring_rdata_r;
  logic [IW-1:0]         ptr_rdata_r;
  logic                  clr_last;

  assign clr_last = (clr_slot_r == SW'(SLOTS - 1)) && (clr_idx_r == IW'(WINDOW - 1));

  // clearing sweep after reset, one ring entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_slot_r <= '0;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_last) begin
        clr_busy_r <= 1'b0;
      end else if (clr_idx_r == IW'(WINDOW - 1)) begin
        clr_idx_r  <= '0;
        clr_slot_r <= clr_slot_r + 1'b1;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      ring_mem[clr_slot_r][clr_idx_r] <= '0;
    end else if (ring_we) begin
      ring_mem[slot][wr_idx] <= wr_data;
    end
    ring_rdata_r <= ring_mem[slot][rd_idx];
  end

  // write pointer per slot
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      ptr_mem[clr_slot_r] <= '0;
    end else if (ptr_we) begin
      ptr_mem[slot] <= ptr_wdata;
    end
    ptr_rdata_r <= ptr_mem[slot];
  end

  assign clr_busy   = clr_busy_r;
  assign ring_rdata = ring_rdata_r;
  assign ptr_rdata  = ptr_rdata_r;

endmodule

// ===== design/wisu_div.sv =====
module wisu_div #(
  parameter int DVW = 47,
  parameter int DSW = 7,
  localparam int STW = $clog2(DVW + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVW-1:0]               dividend,
  input  logic [DSW-1:0]               divisor,
  output logic                         busy,
  output logic [wisu_pkg::AVG_W-1:0]   quotient
);
  import wisu_pkg::*;

  logic [DVW-1:0]   dv_r;
  logic [DSW-1:0]   dsr_r;
  logic [DSW-1:0]   rem_r;
  logic [AVG_W-1:0] q_r;
  logic [STW-1:0]   step_r;
  logic             busy_r;
  logic [DSW:0]     rem_sh;
  logic [DSW:0]     rem_sub;
  logic             ge;

  // one restoring step: shift in a dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dv_r[DVW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STW'(DVW);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath, quotient keeps its low bits only
  always_ff @(posedge clk) begin
    if (start) begin
      dv_r  <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dv_r  <= dv_r << 1;
      rem_r <= ge ? DSW'(rem_sub) : DSW'(rem_sh);
      q_r   <= {q_r[AVG_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== design/wisu_checker.sv =====
module wisu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [wisu_pkg::AVG_W-1:0]        out_average_q8,
  input logic [wisu_pkg::MAX_W-1:0]        out_maximum,
  input logic [wisu_pkg::COUNT_W-1:0]      out_valid_count
);
  import wisu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_q8) &&
      $stable(out_maximum) && $stable(out_valid_count))
    else $error("result changed while stalled");

  // an empty window reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_valid_count == '0) |-> (out_average_q8 == '0) && (out_maximum == '0))
    else $error("nonzero statistics with zero count");

  // one item in flight: ready drops after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after input transfer");

  // reset empties the output and starts the clearing sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind windowed_interval_stats_unit wisu_checker u_wisu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_average_q8  (out_average_q8),
  .out_maximum     (out_maximum),
  .out_valid_count (out_valid_count)
);
